@@ sv/pvbm_pkg.sv @@
// Shared types and codes for the pair/variable two-way map.
`default_nettype none
package pvbm_pkg;

  localparam int KEY_W  = 20;
  localparam int VAR_W  = 10;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [ACT_W-1:0] ACT_STORE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PAIR2VAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_VAR2PAIR  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SET_LEMMA = 3'd4;
  localparam logic [ACT_W-1:0] ACT_GET_LEMMA = 3'd5;
  localparam logic [ACT_W-1:0] ACT_TEST      = 3'd6;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_VAR_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_VAR_UNMAPPED = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_ORDERED  = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] dag_low;
    logic [KEY_W-1:0] dag_high;
    logic [VAR_W-1:0] var_index;
  } in_t;

  typedef struct packed {
    logic [VAR_W-1:0]  found_var;
    logic [KEY_W-1:0]  pair_low_out;
    logic [KEY_W-1:0]  pair_high_out;
    logic              flag_out;
    logic [STAT_W-1:0] status;
  } out_t;

  // One word of the pair table.
  typedef struct packed {
    logic             valid;
    logic             lemma;
    logic [VAR_W-1:0] var_num;
    logic [KEY_W-1:0] key_low;
    logic [KEY_W-1:0] key_high;
  } entry_t;

  // Verdict of the compare unit on one table word.
  typedef struct packed {
    logic hit;
    logic free;
    logic linked;
  } scan_hit_t;

endpackage
`default_nettype wire

@@ sv/pvbm_match.sv @@
// Shared compare unit: checks one table word against the requested pair key and reports whether it is free or linked.
`default_nettype none
module pvbm_match
  import pvbm_pkg::*;
(
  input  entry_t           word,
  input  logic [KEY_W-1:0] key_low,
  input  logic [KEY_W-1:0] key_high,
  output scan_hit_t        verdict
);

  always_comb begin
    verdict.hit    = word.valid && (word.key_low == key_low) && (word.key_high == key_high);
    verdict.free   = !word.valid;
    verdict.linked = word.valid && (word.var_num != '0);
  end

endmodule
`default_nettype wire

@@ sv/pair_variable_bidirectional_map_top.sv @@
// Top level of the pair/variable two-way map: sequencer, table and slot memories.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready  in_data  (pvbm_pkg::in_t)
//  out_     output     out_valid/out_ready  out_data (pvbm_pkg::out_t)
//
// Store, pair-to-var, set lemma, get lemma and clear links scan the whole table through
// one compare unit, one entry per cycle; store then reads its variable slot, and a request
// that is rejected before the scan goes straight to the result.
// Var-to-pair, remove and test use the slot and table memory ports only, with no scan.
// After reset a clearing pass writes every table word and variable slot before the
// first request is taken. A result waits in the output register while the next request
// is accepted; a request finishing while that register is still full stalls until it empties.
`default_nettype none
module pair_variable_bidirectional_map_top
  import pvbm_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int VAR_SLOTS   = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int TW        = $clog2(TABLE_DEPTH);
  localparam int SW        = $clog2(VAR_SLOTS);
  localparam int CLR_DEPTH = (TABLE_DEPTH > VAR_SLOTS) ? TABLE_DEPTH : VAR_SLOTS;
  localparam int CLW       = $clog2(CLR_DEPTH);

  localparam logic [2:0] S_CLR      = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SLOT_CHK = 3'd4;
  localparam logic [2:0] S_ENT_CHK  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  typedef struct packed {
    logic          mapped;
    logic [TW-1:0] idx;
  } slot_word_t;

  // Memories
  entry_t     ent_mem [TABLE_DEPTH];
  slot_word_t slot_mem [VAR_SLOTS];

  logic          ent_we, ent_re;
  logic [TW-1:0] ent_waddr, ent_raddr;
  entry_t        ent_wdata, ent_rdata_r;
  logic          slot_we, slot_re;
  logic [SW-1:0] slot_waddr, slot_raddr;
  slot_word_t    slot_wdata, slot_rdata_r;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_r <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata_r <= slot_mem[slot_raddr];
    end
  end

  // Sequencer state
  logic [2:0]     state_r, state_nxt;
  logic [CLW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [TW:0]    cnt_r, cnt_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic [TW-1:0]  rd_idx_r, rd_idx_nxt;
  in_t            item_r, item_nxt;
  out_t           res_r, res_nxt;
  out_t           out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           hit_r, hit_nxt;
  logic [TW-1:0]  hit_idx_r, hit_idx_nxt;
  entry_t         hit_word_r, hit_word_nxt;
  logic           free_r, free_nxt;
  logic [TW-1:0]  free_idx_r, free_idx_nxt;

  scan_hit_t      verdict;
  logic           ordered, var_ok, var_nz, scan_end;
  logic [SW-1:0]  var_slot;

  pvbm_match u_match (
    .word     (ent_rdata_r),
    .key_low  (item_r.dag_low),
    .key_high (item_r.dag_high),
    .verdict  (verdict)
  );

  assign ordered  = item_r.dag_low < item_r.dag_high;
  assign var_ok   = 32'(item_r.var_index) < VAR_SLOTS;
  assign var_nz   = item_r.var_index != '0;
  assign var_slot = SW'(item_r.var_index);
  assign scan_end = (cnt_r == (TW+1)'(TABLE_DEPTH)) && !rd_pend_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_word_nxt  = hit_word_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    ent_we        = 1'b0;
    ent_waddr     = '0;
    ent_wdata     = '0;
    ent_re        = 1'b0;
    ent_raddr     = '0;
    slot_we       = 1'b0;
    slot_waddr    = '0;
    slot_wdata    = '0;
    slot_re       = 1'b0;
    slot_raddr    = '0;

    unique case (state_r)
      S_CLR: begin
        ent_we      = 32'(clr_cnt_r) < TABLE_DEPTH;
        ent_waddr   = TW'(clr_cnt_r);
        slot_we     = 32'(clr_cnt_r) < VAR_SLOTS;
        slot_waddr  = SW'(clr_cnt_r);
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLW'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        unique case (item_r.action)
          ACT_STORE: begin
            if (!ordered) begin
              res_nxt.status = ST_NOT_ORDERED;
              state_nxt      = S_DONE;
            end else if (!var_nz || !var_ok) begin
              res_nxt.status = ST_VAR_RANGE;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          ACT_PAIR2VAR, ACT_SET_LEMMA, ACT_GET_LEMMA: begin
            if (!ordered) begin
              res_nxt.status = ST_NOT_ORDERED;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          ACT_VAR2PAIR, ACT_REMOVE, ACT_TEST: begin
            if (!var_ok) begin
              res_nxt.status = ST_VAR_RANGE;
              state_nxt      = S_DONE;
            end else begin
              slot_re    = 1'b1;
              slot_raddr = var_slot;
              state_nxt  = S_SLOT_CHK;
            end
          end
          ACT_CLEAR: begin
            state_nxt = S_SCAN;
          end
        endcase
      end

      S_SCAN: begin
        // Read side: one table address per cycle.
        if (cnt_r != (TW+1)'(TABLE_DEPTH)) begin
          ent_re      = 1'b1;
          ent_raddr   = cnt_r[TW-1:0];
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = cnt_r[TW-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end
        // Compare side: the word read in the previous cycle.
        if (rd_pend_r) begin
          if (verdict.hit && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = rd_idx_r;
            hit_word_nxt = ent_rdata_r;
          end
          if (verdict.free && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          // Every linked entry owns exactly one mapped slot, so clearing both here
          // leaves no mapped slot behind.
          if ((item_r.action == ACT_CLEAR) && verdict.linked) begin
            ent_we             = 1'b1;
            ent_waddr          = rd_idx_r;
            ent_wdata          = ent_rdata_r;
            ent_wdata.var_num  = '0;
            slot_we            = 1'b1;
            slot_waddr         = SW'(ent_rdata_r.var_num);
          end
        end
        if (scan_end) begin
          state_nxt = S_DONE;
          unique case (item_r.action)
            ACT_PAIR2VAR: begin
              res_nxt.found_var = hit_r ? hit_word_r.var_num : '0;
            end
            ACT_GET_LEMMA: begin
              res_nxt.flag_out = hit_r && hit_word_r.lemma;
            end
            ACT_SET_LEMMA: begin
              if (hit_r) begin
                ent_we          = 1'b1;
                ent_waddr       = hit_idx_r;
                ent_wdata       = hit_word_r;
                ent_wdata.lemma = 1'b1;
              end else if (free_r) begin
                ent_we             = 1'b1;
                ent_waddr          = free_idx_r;
                ent_wdata.valid    = 1'b1;
                ent_wdata.lemma    = 1'b1;
                ent_wdata.key_low  = item_r.dag_low;
                ent_wdata.key_high = item_r.dag_high;
              end else begin
                res_nxt.status = ST_TABLE_FULL;
              end
            end
            ACT_STORE: begin
              slot_re    = 1'b1;
              slot_raddr = var_slot;
              state_nxt  = S_SLOT_CHK;
            end
            ACT_VAR2PAIR, ACT_REMOVE, ACT_TEST, ACT_CLEAR: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SLOT_CHK: begin
        state_nxt = S_DONE;
        priority if (item_r.action == ACT_STORE) begin
          if (slot_rdata_r.mapped) begin
            if (!(hit_r && (slot_rdata_r.idx == hit_idx_r)
                  && (hit_word_r.var_num == item_r.var_index))) begin
              res_nxt.status = ST_VAR_RANGE;
            end
          end else if (hit_r) begin
            if (hit_word_r.var_num != '0) begin
              res_nxt.status = ST_VAR_RANGE;
            end else begin
              ent_we            = 1'b1;
              ent_waddr         = hit_idx_r;
              ent_wdata         = hit_word_r;
              ent_wdata.var_num = item_r.var_index;
              slot_we           = 1'b1;
              slot_waddr        = var_slot;
              slot_wdata.mapped = 1'b1;
              slot_wdata.idx    = hit_idx_r;
            end
          end else if (free_r) begin
            ent_we             = 1'b1;
            ent_waddr          = free_idx_r;
            ent_wdata.valid    = 1'b1;
            ent_wdata.var_num  = item_r.var_index;
            ent_wdata.key_low  = item_r.dag_low;
            ent_wdata.key_high = item_r.dag_high;
            slot_we            = 1'b1;
            slot_waddr         = var_slot;
            slot_wdata.mapped  = 1'b1;
            slot_wdata.idx     = free_idx_r;
          end else begin
            res_nxt.status = ST_TABLE_FULL;
          end
        end else if (item_r.action == ACT_TEST) begin
          res_nxt.flag_out = slot_rdata_r.mapped;
        end else if (!slot_rdata_r.mapped) begin
          res_nxt.status = ST_VAR_UNMAPPED;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = slot_rdata_r.idx;
          state_nxt = S_ENT_CHK;
        end
      end

      S_ENT_CHK: begin
        state_nxt = S_DONE;
        if (item_r.action == ACT_VAR2PAIR) begin
          res_nxt.pair_low_out  = ent_rdata_r.key_low;
          res_nxt.pair_high_out = ent_rdata_r.key_high;
        end else begin
          // Remove: a lemma entry stays in the table without its variable.
          slot_we    = 1'b1;
          slot_waddr = var_slot;
          ent_we     = 1'b1;
          ent_waddr  = slot_rdata_r.idx;
          ent_wdata  = ent_rdata_r;
          if (ent_rdata_r.lemma) begin
            ent_wdata.var_num = '0;
          end else begin
            ent_wdata.valid = 1'b0;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_word_r <= hit_word_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> state_r != S_IDLE)
    else $error("table written while the sequencer is idle");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (TW+1)'(TABLE_DEPTH))
    else $error("scan counter ran past the table depth");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !out_valid_r |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished request not moved to the output register");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_NOT_ORDERED)
    else $error("result status outside the defined codes");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == S_CHECK) && !hit_r && !free_r)
    else $error("accepted request did not start with cleared scan results");
`endif

endmodule
`default_nettype wire

@@ verif/pair_variable_bidirectional_map_top_tb.sv @@
// Self-checking testbench for the pair/variable two-way map: random and directed requests.
`timescale 1ns / 100ps
module pair_variable_bidirectional_map_top_tb;
  import pvbm_pkg::*;

  localparam int DEPTH   = 256;
  localparam int SLOTS   = 1024;
  localparam int KEY_TOP = (1 << KEY_W) - 1;
  localparam int MAX_GAP = 17;
  localparam int POOL    = 24;
  localparam int FILL    = 280;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  pair_variable_bidirectional_map_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the pair table and the variable slots.
  logic             tbl_used  [DEPTH];
  logic             tbl_lemma [DEPTH];
  logic [KEY_W-1:0] tbl_lo    [DEPTH];
  logic [KEY_W-1:0] tbl_hi    [DEPTH];
  logic [VAR_W-1:0] tbl_var   [DEPTH];
  logic             var_linked[SLOTS];
  int               var_entry [SLOTS];

  in_t  pending_reqs[$];
  out_t expected_answers[$];
  int   pool_lo[POOL];
  int   pool_hi[POOL];

  int offered = 0;
  int accepted = 0;
  int answered = 0;
  int answers_seen = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int recv_hold = 0;
  int errors = 0;

  function automatic int pair_slot(logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_used[i] && tbl_lo[i] == lo && tbl_hi[i] == hi) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < DEPTH; i++)
      if (!tbl_used[i]) return i;
    return -1;
  endfunction

  function automatic void claim_slot(int e, logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi,
                                     logic [VAR_W-1:0] v, logic lemma);
    tbl_used[e]  = 1'b1;
    tbl_lo[e]    = lo;
    tbl_hi[e]    = hi;
    tbl_var[e]   = v;
    tbl_lemma[e] = lemma;
  endfunction

  // Applies one request to the shadow state and returns the answer it must give.
  // With 1024 slots every 10-bit variable number is in range; only a store refuses zero.
  task automatic map_apply(input in_t rq, output out_t ans);
    int e;
    logic ordered;
    logic [VAR_W-1:0] v;
    ans = '0;
    v = rq.var_index;
    ordered = rq.dag_low < rq.dag_high;
    case (rq.action)
      ACT_STORE: begin
        if (!ordered) ans.status = ST_NOT_ORDERED;
        else if (v == '0) ans.status = ST_VAR_RANGE;
        else begin
          e = pair_slot(rq.dag_low, rq.dag_high);
          if (var_linked[v]) begin
            // Relinking a variable to its own pair is a silent no-op.
            if (e < 0 || var_entry[v] != e || tbl_var[e] != v) ans.status = ST_VAR_RANGE;
          end else if (e >= 0) begin
            if (tbl_var[e] != '0) ans.status = ST_VAR_RANGE;
            else begin
              tbl_var[e] = v;
              var_linked[v] = 1'b1;
              var_entry[v] = e;
            end
          end else begin
            e = free_slot();
            if (e < 0) ans.status = ST_TABLE_FULL;
            else begin
              claim_slot(e, rq.dag_low, rq.dag_high, v, 1'b0);
              var_linked[v] = 1'b1;
              var_entry[v] = e;
            end
          end
        end
      end
      ACT_PAIR2VAR: begin
        if (!ordered) ans.status = ST_NOT_ORDERED;
        else begin
          e = pair_slot(rq.dag_low, rq.dag_high);
          if (e >= 0) ans.found_var = tbl_var[e];
        end
      end
      ACT_VAR2PAIR: begin
        if (!var_linked[v]) ans.status = ST_VAR_UNMAPPED;
        else begin
          ans.pair_low_out  = tbl_lo[var_entry[v]];
          ans.pair_high_out = tbl_hi[var_entry[v]];
        end
      end
      ACT_REMOVE: begin
        if (!var_linked[v]) ans.status = ST_VAR_UNMAPPED;
        else begin
          e = var_entry[v];
          var_linked[v] = 1'b0;
          // An entry whose lemma is done survives with no variable.
          if (tbl_lemma[e]) tbl_var[e] = '0;
          else tbl_used[e] = 1'b0;
        end
      end
      ACT_SET_LEMMA: begin
        if (!ordered) ans.status = ST_NOT_ORDERED;
        else begin
          e = pair_slot(rq.dag_low, rq.dag_high);
          if (e >= 0) tbl_lemma[e] = 1'b1;
          else begin
            e = free_slot();
            if (e < 0) ans.status = ST_TABLE_FULL;
            else claim_slot(e, rq.dag_low, rq.dag_high, '0, 1'b1);
          end
        end
      end
      ACT_GET_LEMMA: begin
        if (!ordered) ans.status = ST_NOT_ORDERED;
        else begin
          e = pair_slot(rq.dag_low, rq.dag_high);
          if (e >= 0) ans.flag_out = tbl_lemma[e];
        end
      end
      ACT_TEST: ans.flag_out = var_linked[v];
      ACT_CLEAR: begin
        for (int i = 0; i < DEPTH; i++)
          if (tbl_used[i]) tbl_var[i] = '0;
        for (int i = 0; i < SLOTS; i++)
          var_linked[i] = 1'b0;
      end
    endcase
  endtask

  function automatic in_t make_req(logic [ACT_W-1:0] act, int lo, int hi, int v);
    in_t r;
    r.action    = act;
    r.dag_low   = KEY_W'(lo);
    r.dag_high  = KEY_W'(hi);
    r.var_index = VAR_W'(v);
    return r;
  endfunction

  // Mostly pairs and variables from small pools so that requests hit each other.
  function automatic in_t random_req();
    in_t r;
    int pick;
    int k;
    int lo;
    pick = $urandom_range(0, 99);
    r.action = pick < 28 ? ACT_STORE :
               pick < 40 ? ACT_PAIR2VAR :
               pick < 50 ? ACT_VAR2PAIR :
               pick < 62 ? ACT_REMOVE :
               pick < 72 ? ACT_SET_LEMMA :
               pick < 84 ? ACT_GET_LEMMA :
               pick < 97 ? ACT_TEST : ACT_CLEAR;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      k = $urandom_range(0, POOL - 1);
      r.dag_low  = KEY_W'(pool_lo[k]);
      r.dag_high = KEY_W'(pool_hi[k]);
    end else if (pick < 93) begin
      lo = $urandom_range(0, KEY_TOP - 1);
      r.dag_low  = KEY_W'(lo);
      r.dag_high = KEY_W'($urandom_range(lo + 1, KEY_TOP));
    end else if (pick < 96) begin
      r.dag_low  = KEY_W'($urandom);
      r.dag_high = r.dag_low;
    end else begin
      r.dag_low  = KEY_W'($urandom);
      r.dag_high = KEY_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) r.var_index = VAR_W'($urandom_range(1, 30));
    else if (pick < 95) r.var_index = VAR_W'($urandom_range(0, SLOTS - 1));
    else r.var_index = $urandom_range(0, 1) ? '0 : VAR_W'(SLOTS - 1);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Driver: offers the next request after a random gap, holding it until taken.
  always @(negedge clk) begin
    logic next_valid;
    in_t  next_data;
    next_valid = in_valid;
    next_data  = in_data;
    if (rst_n) begin
      if (in_valid && accepted == offered) next_valid = 1'b0;
      if (!next_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_reqs.size() > 0) begin
          next_data  = pending_reqs.pop_front();
          next_valid = 1'b1;
          offered++;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 19) == 0) send_calm = 30;
          end
        end
      end
    end
    in_valid <= next_valid;
    in_data  <= next_data;
  end

  // Receiver: may stall after each result, and twice holds off long enough to back up the block.
  always @(negedge clk) begin
    if (rst_n) begin
      if (answered != answers_seen) begin
        answers_seen = answered;
        if (recv_calm > 0) begin
          recv_calm--;
          recv_gap = 0;
        end else begin
          recv_gap = $urandom_range(0, MAX_GAP);
          if ($urandom_range(0, 19) == 0) recv_calm = 30;
        end
        if (answered == 200 || answered == 1400) recv_hold = 1500;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result, then records the request taken at this edge.
  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        answered++;
        if (expected_answers.size() == 0) begin
          $error("result with no request outstanding: %p", got);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          check_field("found_var", want.found_var, got.found_var);
          check_field("pair_low_out", want.pair_low_out, got.pair_low_out);
          check_field("pair_high_out", want.pair_high_out, got.pair_high_out);
          check_field("flag_out", want.flag_out, got.flag_out);
          check_field("status", want.status, got.status);
        end
      end
      if (in_valid && in_ready) begin
        map_apply(in_data, want);
        expected_answers.push_back(want);
        accepted++;
      end
    end
  end

  initial begin
    int lo;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_lemma[i] = 1'b0;
      tbl_lo[i]    = '0;
      tbl_hi[i]    = '0;
      tbl_var[i]   = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      var_linked[i] = 1'b0;
      var_entry[i]  = 0;
    end

    pool_lo[0] = 0;
    pool_hi[0] = KEY_TOP;
    pool_lo[1] = KEY_TOP - 1;
    pool_hi[1] = KEY_TOP;
    for (int i = 2; i < POOL; i++) begin
      pool_lo[i] = $urandom_range(0, KEY_TOP - 1);
      pool_hi[i] = $urandom_range(pool_lo[i] + 1, KEY_TOP);
    end

    // Directed requests: every action, the ordering, range and unmapped error codes and the edge cases.
    pending_reqs.push_back(make_req(ACT_TEST, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_TEST, 0, 0, SLOTS - 1));
    pending_reqs.push_back(make_req(ACT_VAR2PAIR, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_STORE, 5, 5, 1));
    pending_reqs.push_back(make_req(ACT_STORE, 9, 3, 1));
    pending_reqs.push_back(make_req(ACT_STORE, 3, 9, 0));
    pending_reqs.push_back(make_req(ACT_STORE, 3, 9, 1));
    pending_reqs.push_back(make_req(ACT_STORE, 3, 9, 1));
    pending_reqs.push_back(make_req(ACT_STORE, 4, 9, 1));
    pending_reqs.push_back(make_req(ACT_STORE, 3, 9, 2));
    pending_reqs.push_back(make_req(ACT_PAIR2VAR, 3, 9, 0));
    pending_reqs.push_back(make_req(ACT_PAIR2VAR, 9, 3, 0));
    pending_reqs.push_back(make_req(ACT_VAR2PAIR, 0, 0, 1));
    pending_reqs.push_back(make_req(ACT_SET_LEMMA, 3, 9, 0));
    pending_reqs.push_back(make_req(ACT_SET_LEMMA, 3, 9, 0));
    pending_reqs.push_back(make_req(ACT_GET_LEMMA, 3, 9, 0));
    pending_reqs.push_back(make_req(ACT_GET_LEMMA, 7, 8, 0));
    pending_reqs.push_back(make_req(ACT_GET_LEMMA, 8, 8, 0));
    pending_reqs.push_back(make_req(ACT_SET_LEMMA, 9, 1, 0));
    pending_reqs.push_back(make_req(ACT_STORE, 0, KEY_TOP, SLOTS - 1));
    pending_reqs.push_back(make_req(ACT_VAR2PAIR, 0, 0, SLOTS - 1));
    pending_reqs.push_back(make_req(ACT_REMOVE, 0, 0, 1));
    pending_reqs.push_back(make_req(ACT_STORE, 3, 9, 5));
    pending_reqs.push_back(make_req(ACT_REMOVE, 0, 0, SLOTS - 1));
    pending_reqs.push_back(make_req(ACT_SET_LEMMA, 16, 32, 0));
    pending_reqs.push_back(make_req(ACT_CLEAR, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_TEST, 0, 0, 5));

    repeat (600) pending_reqs.push_back(random_req());

    // Fill the table with distinct pairs until it overflows, then free it again.
    for (int i = 0; i < FILL; i++) begin
      lo = (i << 11) | $urandom_range(0, 2047);
      pending_reqs.push_back(make_req(ACT_STORE, lo, $urandom_range(lo + 1, KEY_TOP), 300 + i));
    end
    repeat (3) begin
      lo = $urandom_range(0, KEY_TOP - 1);
      pending_reqs.push_back(make_req(ACT_SET_LEMMA, lo, $urandom_range(lo + 1, KEY_TOP), 0));
    end
    repeat (12) pending_reqs.push_back(random_req());
    for (int i = 0; i < FILL; i++) begin
      pending_reqs.push_back(make_req(ACT_REMOVE, 0, 0, 300 + i));
      if (i % 50 == 0) pending_reqs.push_back(random_req());
    end

    repeat (450) pending_reqs.push_back(random_req());

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
